[rtl/pslt_pkg.sv]
// Package for the per-source sequence loss tracker.
// Holds table sizing, register map, status codes and the request/result types.
// No dependencies.
package pslt_pkg;

    // Source table sizing
    localparam int NUM_SOURCES = 8;
    localparam int SRC_IDX_W   = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int SRC_ID_W    = 8;
    localparam int SEQ_W       = 16;
    localparam int CNT_W       = 32;
    localparam int TIME_W      = 32;
    localparam int AXIS_W      = 12;
    localparam int NIBBLE_W    = 4;
    localparam int PRESS_RAW_W = 24;
    localparam int PRESS_W     = 18;

    // Pressure is divided by 64
    localparam int PRESSURE_SHIFT = 6;

    // Configuration register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_GAP_THRESHOLD = '0;
    localparam logic [SEQ_W-1:0]   GAP_THRESHOLD_RESET = 16'd500;

    // Result status codes
    localparam int STATUS_W = 3;
    localparam logic [STATUS_W-1:0] ST_FIRST     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IN_ORDER  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LOSS      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LARGE_GAP = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

    // One received packet header
    typedef struct packed {
        logic [SRC_ID_W-1:0]    source_id;
        logic [SEQ_W-1:0]       sequence_number;
        logic [TIME_W-1:0]      receive_time;
        logic [15:0]            packed_x_word;
        logic [15:0]            packed_y_word;
        logic [15:0]            packed_z_word;
        logic [PRESS_RAW_W-1:0] pressure_raw;
    } pkt_item_t;

    // One result
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [SEQ_W-1:0]         gap_seen;
        logic [CNT_W-1:0]         received_count;
        logic [CNT_W-1:0]         lost_count;
        logic signed [AXIS_W-1:0] axis_x;
        logic signed [AXIS_W-1:0] axis_y;
        logic signed [AXIS_W-1:0] axis_z;
        logic [NIBBLE_W-1:0]      force_intensity;
        logic [NIBBLE_W-1:0]      force_pattern;
        logic [PRESS_W-1:0]       pressure_pascal;
    } res_item_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
    } pslt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;
    } pslt_sts_t;

endpackage

[rtl/per_source_sequence_loss_tracker_top.sv]
// Per-source sequence loss tracker, top level.
// Holds the APB configuration register; instantiates pslt_ctrl and pslt_datapath.
// Depends on pslt_pkg.
//
// Usage:
//   Request channel (pkt_valid/pkt_stall/pkt) carries one packet header.
//   It is taken at a clock edge with pkt_valid high and pkt_stall low.
//   Result channel (res_valid/res_stall/res) returns one result per request,
//   in order: status, sequence gap, the source's counts after the update and
//   the unpacked sensor fields.
//   The request is registered at capture; the update step then writes its
//   result to the result register. No new request is taken during the update
//   step, which does the read-modify-write of one source table entry.
//   A stalled result stays in its output register; the next request is still
//   taken and waits in the update step until that register is free.
//   Reset clears all table valid bits at once (no clearing pass) and sets
//   gap_threshold to 500. gap_threshold is at byte address 0; the user must
//   write it only while the block is idle, which the block does not enforce.
module per_source_sequence_loss_tracker_top
    import pslt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pkt_valid,
    output logic               pkt_stall,
    input  pkt_item_t          pkt,
    output logic               res_valid,
    input  logic               res_stall,
    output res_item_t          res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [SEQ_W-1:0] gap_thr_reg;
    logic             reg_sel;
    pslt_cmd_t        cmd;
    pslt_sts_t        sts;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[PADDR_W-1:2] == REG_GAP_THRESHOLD);
    assign prdata  = reg_sel ? PDATA_W'(gap_thr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_thr_reg <= GAP_THRESHOLD_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            gap_thr_reg <= pwdata[SEQ_W-1:0];
        end
    end

    pslt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    pslt_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .pkt           (pkt),
        .gap_threshold (gap_thr_reg),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .res           (res)
    );

`ifndef SYNTHESIS
    // A taken request always occupies the update step next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && !pkt_stall |=> pkt_stall)
        else $error("request taken without entering update step");

    // A new result only appears out of the update step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(pkt_stall))
        else $error("result appeared without an update step");

    // Invalid source leaves counts and gap at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == ST_INVALID |->
            res.gap_seen == '0 && res.received_count == '0 && res.lost_count == '0)
        else $error("invalid source result carries counts");

    // First packet of a source starts the counts fresh
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == ST_FIRST |->
            res.received_count == 32'd1 && res.lost_count == '0 && res.gap_seen == '0)
        else $error("first packet result has wrong counts");
`endif

endmodule

[rtl/pslt_ctrl.sv]
// Controller for the sequence loss tracker: two-state sequencer that captures
// a request, then commits the table update once the result register is free.
// Depends on pslt_pkg.
module pslt_ctrl
    import pslt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pkt_valid,
    output logic      pkt_stall,
    input  pslt_sts_t sts,
    output pslt_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_CALC = 1'b1;

    logic state_reg;
    logic state_next;

    // Hold off new requests while one is in the update step
    assign pkt_stall   = (state_reg == S_CALC);
    assign cmd.capture = (state_reg == S_IDLE) && pkt_valid;
    assign cmd.commit  = (state_reg == S_CALC) && !sts.out_busy;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pkt_valid)
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (!sts.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/pslt_datapath.sv]
// Datapath for the sequence loss tracker: request register, per-source table,
// gap compute and result register.
// Depends on pslt_pkg.
module pslt_datapath
    import pslt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  pslt_cmd_t        cmd,
    output pslt_sts_t        sts,
    input  pkt_item_t        pkt,
    input  logic [SEQ_W-1:0] gap_threshold,
    output logic             res_valid,
    input  logic             res_stall,
    output res_item_t        res
);

    // Per-source table; only the valid bits need reset
    logic              valid_reg [NUM_SOURCES];
    logic [SEQ_W-1:0]  seq_reg   [NUM_SOURCES];
    logic [CNT_W-1:0]  rcv_reg   [NUM_SOURCES];
    logic [CNT_W-1:0]  lost_reg  [NUM_SOURCES];
    logic [TIME_W-1:0] time_reg  [NUM_SOURCES];

    pkt_item_t item_reg;
    res_item_t res_reg;
    res_item_t res_next;
    logic      res_valid_reg;

    logic                 id_ok;
    logic [SRC_IDX_W-1:0] idx;
    logic                 entry_valid;
    logic [SEQ_W-1:0]     expected;
    logic [SEQ_W-1:0]     gap;
    logic [CNT_W-1:0]     rcv_new;
    logic [CNT_W-1:0]     lost_new;
    logic [SEQ_W-1:0]     seq_new;

    assign sts.out_busy = res_valid_reg && res_stall;
    assign res_valid    = res_valid_reg;
    assign res          = res_reg;

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= pkt;
        end
    end

    // Entry lookup and gap
    assign id_ok = (item_reg.source_id != '0)
                && (item_reg.source_id <= SRC_ID_W'(NUM_SOURCES));
    assign idx         = SRC_IDX_W'(item_reg.source_id - SRC_ID_W'(1));
    assign entry_valid = valid_reg[idx];
    assign expected    = seq_reg[idx] + SEQ_W'(1);
    assign gap         = item_reg.sequence_number - expected;

    // Result and entry update
    always_comb
    begin
        res_next.status          = ST_INVALID;
        res_next.gap_seen        = '0;
        res_next.received_count  = '0;
        res_next.lost_count      = '0;
        res_next.axis_x          = item_reg.packed_x_word[15:NIBBLE_W];
        res_next.axis_y          = item_reg.packed_y_word[15:NIBBLE_W];
        res_next.axis_z          = item_reg.packed_z_word[15:NIBBLE_W];
        res_next.force_intensity = item_reg.packed_x_word[NIBBLE_W-1:0];
        res_next.force_pattern   = item_reg.packed_y_word[NIBBLE_W-1:0];
        res_next.pressure_pascal =
            PRESS_W'(item_reg.pressure_raw >> PRESSURE_SHIFT);
        rcv_new  = '0;
        lost_new = '0;
        seq_new  = item_reg.sequence_number;
        if (id_ok)
        begin
            if (!entry_valid)
            begin
                res_next.status = ST_FIRST;
                rcv_new         = CNT_W'(1);
                lost_new        = '0;
            end
            else
            begin
                rcv_new  = rcv_reg[idx] + CNT_W'(1);
                lost_new = lost_reg[idx];
                if (gap == '0)
                begin
                    res_next.status = ST_IN_ORDER;
                end
                else if (gap < gap_threshold)
                begin
                    res_next.status = ST_LOSS;
                    lost_new        = lost_reg[idx] + CNT_W'(gap);
                end
                else
                begin
                    res_next.status = ST_LARGE_GAP;
                end
                res_next.gap_seen = gap;
            end
            res_next.received_count = rcv_new;
            res_next.lost_count     = lost_new;
        end
    end

    // Table valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (cmd.commit && id_ok)
        begin
            valid_reg[idx] <= 1'b1;
        end
    end

    // Table payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit && id_ok)
        begin
            seq_reg[idx]  <= seq_new;
            rcv_reg[idx]  <= rcv_new;
            lost_reg[idx] <= lost_new;
            time_reg[idx] <= item_reg.receive_time;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

endmodule

[tb/per_source_sequence_loss_tracker_top_tb.sv]
// Testbench for per_source_sequence_loss_tracker_top: directed and random packet headers,
// each result checked field by field against an in-bench per-source loss tracker.
// Depends on pslt_pkg and the RTL of the tracker.
module per_source_sequence_loss_tracker_top_tb;
    import pslt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PADDR_W-1:0] GAP_THRESHOLD_ADDR = {REG_GAP_THRESHOLD, 2'b00};

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               pkt_valid = 1'b0;
    logic               pkt_stall;
    pkt_item_t          pkt       = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    res_item_t          res;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Tracker copy: per-source table and the loss threshold
    logic               src_seen    [NUM_SOURCES];
    logic [SEQ_W-1:0]   src_seq     [NUM_SOURCES];
    logic [CNT_W-1:0]   src_rcvd    [NUM_SOURCES];
    logic [CNT_W-1:0]   src_lost    [NUM_SOURCES];
    logic [TIME_W-1:0]  src_rx_time [NUM_SOURCES];
    logic [SEQ_W-1:0]   gap_limit;

    res_item_t          due_results [$];
    res_item_t          head_res;
    int                 mismatches  = 0;
    int                 res_index   = 0;
    bit                 src_idle_en = 1'b0;
    bit                 sink_idle_en = 1'b0;

    per_source_sequence_loss_tracker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Update the table copy for one accepted request and return the result it causes
    function automatic res_item_t track_packet(pkt_item_t p);
        res_item_t        r;
        int unsigned      k;
        logic [SEQ_W-1:0] gap;
        r = '0;
        r.axis_x          = p.packed_x_word[15:4];
        r.axis_y          = p.packed_y_word[15:4];
        r.axis_z          = p.packed_z_word[15:4];
        r.force_intensity = p.packed_x_word[NIBBLE_W-1:0];
        r.force_pattern   = p.packed_y_word[NIBBLE_W-1:0];
        r.pressure_pascal = p.pressure_raw[PRESS_RAW_W-1:PRESSURE_SHIFT];
        if (p.source_id == 0 || p.source_id > NUM_SOURCES)
        begin
            r.status = ST_INVALID;
        end
        else
        begin
            k = p.source_id - 1;
            if (!src_seen[k])
            begin
                src_seen[k] = 1'b1;
                src_rcvd[k] = 1;
                src_lost[k] = 0;
                r.status    = ST_FIRST;
            end
            else
            begin
                gap = p.sequence_number - (src_seq[k] + 16'd1);
                if (gap == 0)
                    r.status = ST_IN_ORDER;
                else if (gap < gap_limit)
                begin
                    src_lost[k] = src_lost[k] + gap;
                    r.status    = ST_LOSS;
                end
                else
                    r.status = ST_LARGE_GAP;
                r.gap_seen  = gap;
                src_rcvd[k] = src_rcvd[k] + 1;
            end
            src_seq[k]        = p.sequence_number;
            src_rx_time[k]    = p.receive_time;
            r.received_count  = src_rcvd[k];
            r.lost_count      = src_lost[k];
        end
        return r;
    endfunction

    function automatic pkt_item_t rand_pkt(logic [SRC_ID_W-1:0] id, logic [SEQ_W-1:0] seq);
        pkt_item_t p;
        p.source_id       = id;
        p.sequence_number = seq;
        p.receive_time    = $urandom;
        p.packed_x_word   = 16'($urandom_range(0, 16'hFFFF));
        p.packed_y_word   = 16'($urandom_range(0, 16'hFFFF));
        p.packed_z_word   = 16'($urandom_range(0, 16'hFFFF));
        p.pressure_raw    = 24'($urandom_range(0, 24'hFFFFFF));
        return p;
    endfunction

    // Present one request, hold it until taken, then record its expected result.
    // Valid stays high afterwards so back-to-back requests need no gap.
    task automatic send_pkt(pkt_item_t p);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            pkt_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        pkt_valid <= 1'b1;
        pkt       <= p;
        do @(posedge clk); while (pkt_stall);
        due_results.push_back(track_packet(p));
    endtask

    // Next request of a known source, placed the given gap past its expected sequence
    task automatic send_after_gap(logic [SRC_ID_W-1:0] id, logic [SEQ_W-1:0] gap);
        send_pkt(rand_pkt(id, src_seq[id-1] + 16'd1 + gap));
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic settle();
        pkt_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write gap_threshold over APB, then read it back
    task automatic set_gap_threshold(logic [SEQ_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= GAP_THRESHOLD_ADDR;
        pwdata  <= {{(PDATA_W-SEQ_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        gap_limit = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[SEQ_W-1:0] !== value)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("gap_threshold read back: expected 0x%0h, got 0x%0h", value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Bad source ids with extreme sensor words
    task automatic test_invalid_ids();
        pkt_item_t p;
        p = rand_pkt(8'd0, 16'h0000);
        p.packed_x_word = 16'h8000;
        p.packed_y_word = 16'h7FF0;
        p.packed_z_word = 16'hFFFF;
        p.receive_time  = '0;
        p.pressure_raw  = 24'hFFFFFF;
        send_pkt(p);
        p = rand_pkt(8'(NUM_SOURCES + 1), 16'h5A5A);
        p.packed_x_word = 16'h0000;
        p.packed_y_word = 16'h0000;
        p.packed_z_word = 16'h0000;
        p.receive_time  = '1;
        p.pressure_raw  = '0;
        send_pkt(p);
        p = rand_pkt(8'hFF, 16'hFFFF);
        p.packed_x_word = 16'h7FFF;
        p.packed_y_word = 16'h800F;
        p.packed_z_word = 16'h0008;
        p.pressure_raw  = 24'h00003F;
        send_pkt(p);
        settle();
    endtask

    // First packets, in-order, wrap of the sequence, repeat, loss and restart edges
    task automatic test_sequence_cases();
        pkt_item_t p;
        for (int id = 1; id <= NUM_SOURCES; id++)
        begin
            p = rand_pkt(8'(id), (id == 1) ? 16'hFFFE : 16'($urandom));
            p.receive_time = (id % 2 == 0) ? '1 : '0;
            send_pkt(p);
        end
        send_after_gap(8'd1, 16'd0);
        send_after_gap(8'd1, 16'd0);
        send_after_gap(8'd1, 16'hFFFF);
        send_after_gap(8'd1, 16'd4);
        send_after_gap(8'd1, gap_limit - 16'd1);
        send_after_gap(8'd1, gap_limit);
        settle();
    endtask

    // Empty loss window at thresholds zero and one, widest window at the top value
    task automatic test_threshold_extremes();
        set_gap_threshold(16'd0);
        send_after_gap(8'd2, 16'd1);
        send_after_gap(8'd2, 16'd0);
        settle();
        set_gap_threshold(16'd1);
        send_after_gap(8'd2, 16'd1);
        settle();
        set_gap_threshold(16'hFFFF);
        send_after_gap(8'd2, 16'hFFFE);
        send_after_gap(8'd2, 16'hFFFF);
        settle();
        set_gap_threshold(16'd2);
        send_after_gap(8'd2, 16'd1);
        send_after_gap(8'd2, 16'd2);
        settle();
    endtask

    // Mostly well-formed streams per source, with gaps, restarts, repeats and bad ids
    task automatic test_random();
        int               r;
        int               lim;
        logic [SRC_ID_W-1:0] id;
        for (int ph = 0; ph < 5; ph++)
        begin
            settle();
            case (ph)
                0: set_gap_threshold(16'($urandom_range(1, 16'hFFFF)));
                1: set_gap_threshold(16'($urandom_range(2, 40)));
                2: set_gap_threshold(16'hFFFF);
                3: set_gap_threshold(16'($urandom_range(100, 1000)));
                default: set_gap_threshold(GAP_THRESHOLD_RESET);
            endcase
            src_idle_en  = (ph < 4) && ($urandom_range(0, 3) != 0);
            sink_idle_en = (ph < 4) && ($urandom_range(0, 3) != 0);
            lim = (gap_limit < 2) ? 2 : 2 * gap_limit;
            if (lim > 16'hFFFF)
                lim = 16'hFFFF;
            for (int n = 0; n < 130; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    id = ($urandom_range(0, 1) == 0) ? 8'd0
                                                     : 8'($urandom_range(NUM_SOURCES + 1, 255));
                    send_pkt(rand_pkt(id, 16'($urandom)));
                end
                else
                begin
                    id = 8'($urandom_range(1, NUM_SOURCES));
                    r  = $urandom_range(0, 99);
                    if (r < 50)
                        send_after_gap(id, 16'd0);
                    else if (r < 75)
                        send_after_gap(id, 16'($urandom_range(1, lim)));
                    else if (r < 85)
                        send_after_gap(id, 16'($urandom));
                    else if (r < 92)
                        send_after_gap(id, 16'hFFFF);
                    else
                        send_pkt(rand_pkt(id, 16'($urandom)));
                end
            end
        end
        settle();
    endtask

    // Result stall in random bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (sink_idle_en && $urandom_range(0, 4) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d %s: expected 0x%0h, got 0x%0h", res_index, fname, want, got);
        end
    endtask

    // Compare each accepted result with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with none expected", res_index);
            end
            else
            begin
                head_res = due_results.pop_front();
                check_field("status", head_res.status, res.status);
                check_field("gap_seen", head_res.gap_seen, res.gap_seen);
                check_field("received_count", head_res.received_count, res.received_count);
                check_field("lost_count", head_res.lost_count, res.lost_count);
                check_field("axis_x", head_res.axis_x, res.axis_x);
                check_field("axis_y", head_res.axis_y, res.axis_y);
                check_field("axis_z", head_res.axis_z, res.axis_z);
                check_field("force_intensity", head_res.force_intensity, res.force_intensity);
                check_field("force_pattern", head_res.force_pattern, res.force_pattern);
                check_field("pressure_pascal", head_res.pressure_pascal, res.pressure_pascal);
            end
            res_index++;
        end
    end

    initial
    begin
        gap_limit = GAP_THRESHOLD_RESET;
        for (int k = 0; k < NUM_SOURCES; k++)
        begin
            src_seen[k]    = 1'b0;
            src_seq[k]     = '0;
            src_rcvd[k]    = '0;
            src_lost[k]    = '0;
            src_rx_time[k] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        test_invalid_ids();
        test_sequence_cases();
        test_threshold_extremes();
        test_random();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Run limit
    initial
    begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/pslt_pkg.sv
rtl/pslt_ctrl.sv
rtl/pslt_datapath.sv
rtl/per_source_sequence_loss_tracker_top.sv
tb/per_source_sequence_loss_tracker_top_tb.sv
